// ===== rtl/open_addressing_hash_table_defines.svh =====
// ---------------------------------------------------------------------------
// open_addressing_hash_table_defines
// assertion macros of the hash table rtl
// ---------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OAHT_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define OAHT_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/oaht_pkg.sv =====
// ---------------------------------------------------------------------------
// oaht_pkg
// field widths, codes and shared types of the hash table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package oaht_pkg;

   // request and response field widths
   localparam int KEY_W    = 31;
   localparam int PAY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int PROBE_W  = 5;
   localparam int SLOT_W   = 4;

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_FOUND    = 2'd2,
      ST_MISSING  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE
   } state_type;

   // write strobes into the slot memories
   typedef struct packed {
      logic wr_used_en;
      logic wr_used_val;
      logic wr_data_en;
   } ram_ctl_type;

endpackage

// ===== rtl/oaht_home_mod.sv =====
// ---------------------------------------------------------------------------
// oaht_home_mod
// home slot unit: key modulo table size by reciprocal multiplication
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module oaht_home_mod
   import oaht_pkg::*;
#(
   parameter int DIVISOR = 16,
   parameter int IDX_W   = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output logic [IDX_W-1:0] home
);

   // scaled reciprocal, exact quotient for every key of KEY_W bits
   localparam int                 FRAC_W  = $clog2(DIVISOR);
   localparam int                 SHIFT   = KEY_W + FRAC_W;
   localparam int                 RECIP_W = KEY_W + 1;
   localparam int                 PROD_W  = KEY_W + RECIP_W;
   localparam longint unsigned    RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_WIDE);
   localparam logic [KEY_W-1:0]   DIV_KEY = KEY_W'(DIVISOR);

   logic              mul_vld_ff, mul_vld_in;
   logic              sub_vld_ff, sub_vld_in;
   logic              done_ff, done_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [KEY_W-1:0]  quot;

   // multiply by the reciprocal, then multiply back and subtract
   always_comb begin
      mul_vld_in = start;
      sub_vld_in = mul_vld_ff;
      done_in    = sub_vld_ff;
      key_in     = start ? key : key_ff;
      prod_in    = mul_vld_ff ? PROD_W'(key_ff) * PROD_W'(RECIP) : prod_ff;
      quot       = KEY_W'(prod_ff >> SHIFT);
      rem_in     = sub_vld_ff ? IDX_W'(key_ff - quot * DIV_KEY) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sub_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mul_vld_ff <= mul_vld_in;
         sub_vld_ff <= sub_vld_in;
         done_ff    <= done_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

// ===== rtl/oaht_slot_ram.sv =====
// ---------------------------------------------------------------------------
// oaht_slot_ram
// slot storage: occupancy memory and key/payload memory, registered reads
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module oaht_slot_ram
   import oaht_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  ram_ctl_type       ctl,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [KEY_W-1:0]  wr_key,
   input  logic [PAY_W-1:0]  wr_payload,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_used,
   output logic [KEY_W-1:0]  rd_key,
   output logic [PAY_W-1:0]  rd_payload
);

   logic                   used_mem [DEPTH];
   logic [KEY_W+PAY_W-1:0] data_mem [DEPTH];
   logic                   rd_used_ff;
   logic [KEY_W+PAY_W-1:0] rd_data_ff;

   // occupancy memory, cleared by the sweep after reset
   always_ff @(posedge clock) begin
      if (ctl.wr_used_en) begin
         used_mem[wr_addr] <= ctl.wr_used_val;
      end
      rd_used_ff <= used_mem[rd_addr];
   end

   // key and payload memory
   always_ff @(posedge clock) begin
      if (ctl.wr_data_en) begin
         data_mem[wr_addr] <= {wr_key, wr_payload};
      end
      rd_data_ff <= data_mem[rd_addr];
   end

   assign rd_used    = rd_used_ff;
   assign rd_key     = rd_data_ff[KEY_W+PAY_W-1:PAY_W];
   assign rd_payload = rd_data_ff[PAY_W-1:0];

endmodule

// ===== rtl/open_addressing_hash_table.sv =====
// ---------------------------------------------------------------------------
// open_addressing_hash_table
// open addressing hash table with linear or quadratic insert probing
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_ready  | kind, quadratic, phone_key, payload_in
//   rsp     | out       | rsp_valid/rsp_ready  | status, probe_count, slot_index, payload_out
//
// a request is accepted, passes the home slot unit (reciprocal multiply, then
// multiply back and subtract) and then probes one slot per cycle; the probe
// loop is bound by the single read port of the slot memories.
// after reset a sweep clears the occupancy memory, requests are held off
// until it ends. a stalled response holds the probe loop on its final slot;
// the next request is taken while a response waits.
//
`timescale 1ns / 1ps

`include "open_addressing_hash_table_defines.svh"

module open_addressing_hash_table
   import oaht_pkg::*;
#(
   parameter int TABLE_SIZE = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic                req_quadratic,
   input  logic [KEY_W-1:0]    req_phone_key,
   input  logic [PAY_W-1:0]    req_payload_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PROBE_W-1:0]  rsp_probe_count,
   output logic [SLOT_W-1:0]   rsp_slot_index,
   output logic [PAY_W-1:0]    rsp_payload_out
);

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int COUNT_W = $clog2(TABLE_SIZE + 1);

   state_type state_ff, state_in;

   logic               kind_ff, kind_in;
   logic               quad_ff, quad_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [PAY_W-1:0]   pay_ff, pay_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [PROBE_W-1:0]  rsp_probe_ff, rsp_probe_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [PAY_W-1:0]    rsp_pay_ff, rsp_pay_in;

   logic             req_accept;
   logic             out_free;
   logic             home_done;
   logic [IDX_W-1:0] home;

   ram_ctl_type      ram_ctl;
   logic             rd_used;
   logic [KEY_W-1:0] rd_key;
   logic [PAY_W-1:0] rd_payload;

   logic [IDX_W:0]     idx_sum;
   logic [IDX_W-1:0]   idx_adv;
   logic [IDX_W:0]     step_sum;
   logic [IDX_W-1:0]   step_adv;
   logic [COUNT_W-1:0] count_inc;

   logic               probe_done;
   logic               probe_write;
   status_type         res_status;
   logic [COUNT_W-1:0] res_probe;
   logic [IDX_W-1:0]   res_slot;
   logic [PAY_W-1:0]   res_pay;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // home slot of the accepted key
   oaht_home_mod #(
      .DIVISOR (TABLE_SIZE),
      .IDX_W   (IDX_W)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .key   (req_phone_key),
      .done  (home_done),
      .home  (home)
   );

   // slot memories, read address follows the next probe index
   oaht_slot_ram #(
      .DEPTH  (TABLE_SIZE),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock      (clock),
      .ctl        (ram_ctl),
      .wr_addr    (idx_ff),
      .wr_key     (key_ff),
      .wr_payload (pay_ff),
      .rd_addr    (idx_in),
      .rd_used    (rd_used),
      .rd_key     (rd_key),
      .rd_payload (rd_payload)
   );

   // next probe index and quadratic step, both modulo table size
   always_comb begin
      idx_sum  = {1'b0, idx_ff} + {1'b0, step_ff};
      idx_adv  = (idx_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
                 IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SIZE)) : idx_sum[IDX_W-1:0];
      step_sum = {1'b0, step_ff} + (IDX_W+1)'(2);
      step_adv = (step_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
                 IDX_W'(step_sum - (IDX_W+1)'(TABLE_SIZE)) : step_sum[IDX_W-1:0];
      count_inc = count_ff + 1'b1;
   end

   // decision on the slot just read
   always_comb begin
      probe_done  = 1'b0;
      probe_write = 1'b0;
      res_status  = ST_MISSING;
      res_probe   = count_ff;
      res_slot    = '0;
      res_pay     = '0;
      if (kind_ff == KIND_INSERT) begin
         if (!rd_used) begin
            probe_done  = 1'b1;
            probe_write = 1'b1;
            res_status  = ST_INSERTED;
            res_slot    = idx_ff;
         end else if (count_inc == COUNT_W'(TABLE_SIZE)) begin
            probe_done = 1'b1;
            res_status = ST_FULL;
            res_probe  = count_inc;
         end
      end else begin
         if (count_ff == COUNT_W'(TABLE_SIZE) || !rd_used) begin
            probe_done = 1'b1;
            res_status = ST_MISSING;
         end else if (rd_key == key_ff) begin
            probe_done = 1'b1;
            res_status = ST_FOUND;
            res_slot   = idx_ff;
            res_pay    = rd_payload;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (idx_ff == IDX_W'(TABLE_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (home_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (probe_done && out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // datapath and outputs per state
   always_comb begin
      kind_in  = kind_ff;
      quad_in  = quad_ff;
      key_in   = key_ff;
      pay_in   = pay_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      count_in = count_ff;
      ram_ctl  = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_probe_in  = rsp_probe_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pay_in    = rsp_pay_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_ctl.wr_used_en  = 1'b1;
            ram_ctl.wr_used_val = 1'b0;
            idx_in = (idx_ff == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               quad_in = req_quadratic && (req_kind == KIND_INSERT);
               key_in  = req_phone_key;
               pay_in  = req_payload_in;
            end
         end
         S_HASH: begin
            if (home_done) begin
               idx_in   = home;
               step_in  = IDX_W'(1);
               count_in = '0;
            end
         end
         S_PROBE: begin
            if (probe_done) begin
               // hold on the final slot until the response register is free
               if (out_free) begin
                  ram_ctl.wr_used_en  = probe_write;
                  ram_ctl.wr_used_val = 1'b1;
                  ram_ctl.wr_data_en  = probe_write;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = res_status;
                  rsp_probe_in  = PROBE_W'(res_probe);
                  rsp_slot_in   = SLOT_W'(res_slot);
                  rsp_pay_in    = res_pay;
               end
            end else begin
               idx_in   = idx_adv;
               count_in = count_inc;
               if (quad_ff) begin
                  step_in = step_adv;
               end
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      quad_ff       <= quad_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      step_ff       <= step_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_probe_ff  <= rsp_probe_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pay_ff    <= rsp_pay_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_probe_count = rsp_probe_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_payload_out = rsp_pay_ff;

   // checks on memory writes and sequencing
   `OAHT_ASSERT_IMP(a_wr_state, clock, reset, ram_ctl.wr_used_en,
      state_ff == S_CLEAR || state_ff == S_PROBE, "slot write outside clear or probe")
   `OAHT_ASSERT_IMP(a_wr_data_used, clock, reset, ram_ctl.wr_data_en,
      ram_ctl.wr_used_en && ram_ctl.wr_used_val, "data write without marking slot used")
   `OAHT_ASSERT_NXT(a_accept_hash, clock, reset, req_accept,
      state_ff == S_HASH, "accepted request did not enter hashing")
   `OAHT_ASSERT_NXT(a_rsp_source, clock, reset, !rsp_valid_ff && state_ff != S_PROBE,
      !rsp_valid_ff, "response raised outside probe loop")

endmodule

// ===== verif/hash_table_checker.sv =====
// ---------------------------------------------------------------------------
// hash_table_checker
// watches both channels of the hash table, predicts each response from a
// private copy of the slot table and compares it field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_table_checker
   import oaht_pkg::*;
#(
   parameter int TABLE_SIZE = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_kind,
   input  logic                req_quadratic,
   input  logic [KEY_W-1:0]    req_phone_key,
   input  logic [PAY_W-1:0]    req_payload_in,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [PROBE_W-1:0]  rsp_probe_count,
   input  logic [SLOT_W-1:0]   rsp_slot_index,
   input  logic [PAY_W-1:0]    rsp_payload_out,
   output int                  failures,
   output int                  outstanding,
   output int                  search_hits,
   output int                  full_inserts
);

   typedef struct {
      status_type         status;
      logic [PROBE_W-1:0] probes;
      logic [SLOT_W-1:0]  slot;
      logic [PAY_W-1:0]   payload;
   } lookup_result_type;

   // shadow copy of the slot memories
   bit               shadow_used [TABLE_SIZE];
   logic [KEY_W-1:0] shadow_key   [TABLE_SIZE];
   logic [PAY_W-1:0] shadow_pay   [TABLE_SIZE];

   lookup_result_type expected_rsp_q [$];

   task automatic report_mismatch(string what, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
      $display("checker: %s mismatch at %0t, got %0h expected %0h", what, $realtime, got, want);
      failures++;
   endtask

   // walk the shadow table for one request, updating it on a successful insert
   function automatic lookup_result_type predict_lookup(logic kind, logic quad,
                                                       logic [KEY_W-1:0] key,
                                                       logic [PAY_W-1:0] pay);
      lookup_result_type r;
      int unsigned       home;
      int unsigned       idx;
      int unsigned       cnt;
      bit                done;
      home      = key % TABLE_SIZE;
      idx       = home;
      cnt       = 0;
      done      = 1'b0;
      r.status  = ST_INSERTED;
      r.probes  = '0;
      r.slot    = '0;
      r.payload = '0;
      if (kind == KIND_INSERT) begin
         // probe until a free slot or the probe budget runs out
         while (!done && shadow_used[idx]) begin
            cnt++;
            if (cnt >= TABLE_SIZE) begin
               done = 1'b1;
            end else if (quad) begin
               idx = (home + cnt * cnt) % TABLE_SIZE;
            end else begin
               idx = (idx + 1) % TABLE_SIZE;
            end
         end
         if (done) begin
            r.status = ST_FULL;
            r.probes = PROBE_W'(TABLE_SIZE);
         end else begin
            shadow_used[idx] = 1'b1;
            shadow_key[idx]  = key;
            shadow_pay[idx]  = pay;
            r.status = ST_INSERTED;
            r.probes = PROBE_W'(cnt);
            r.slot   = SLOT_W'(idx);
         end
      end else begin
         // linear search, stops on a match, a free slot or when every slot was visited
         while (!done && shadow_used[idx] && cnt < TABLE_SIZE) begin
            if (shadow_key[idx] == key) begin
               done = 1'b1;
            end else begin
               idx = (idx + 1) % TABLE_SIZE;
               cnt++;
            end
         end
         r.probes = PROBE_W'(cnt);
         if (done) begin
            r.status  = ST_FOUND;
            r.slot    = SLOT_W'(idx);
            r.payload = shadow_pay[idx];
         end else begin
            r.status = ST_MISSING;
         end
      end
      return r;
   endfunction

   // response check first: a request taken on the same edge cannot own it
   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) shadow_used[i] = 1'b0;
         expected_rsp_q.delete();
         failures     = 0;
         search_hits  = 0;
         full_inserts = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected response, status", PAY_W'(rsp_status), '0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", PAY_W'(rsp_status), PAY_W'(want.status));
               if (rsp_probe_count !== want.probes)
                  report_mismatch("probe_count", PAY_W'(rsp_probe_count), PAY_W'(want.probes));
               if (rsp_slot_index !== want.slot)
                  report_mismatch("slot_index", PAY_W'(rsp_slot_index), PAY_W'(want.slot));
               if (rsp_payload_out !== want.payload)
                  report_mismatch("payload_out", rsp_payload_out, want.payload);
            end
         end
         if (req_valid && req_ready) begin
            want = predict_lookup(req_kind, req_quadratic, req_phone_key, req_payload_in);
            if (want.status == ST_FOUND) search_hits++;
            if (want.status == ST_FULL)  full_inserts++;
            expected_rsp_q.push_back(want);
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// drives the hash table with directed and random insert and search requests,
// random idling on both channels; the checker predicts and compares
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import oaht_pkg::*;
();

   localparam int TABLE_SIZE   = 16;
   localparam int RANDOM_ITEMS = 630;
   localparam int DRAIN_CYCLES = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_kind = KIND_INSERT;
   logic                req_quadratic = 1'b0;
   logic [KEY_W-1:0]    req_phone_key = '0;
   logic [PAY_W-1:0]    req_payload_in = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PROBE_W-1:0]  rsp_probe_count;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic [PAY_W-1:0]    rsp_payload_out;

   int failures;
   int outstanding;
   int search_hits;
   int full_inserts;
   int requests_sent = 0;

   bit               sender_calm = 1'b0;
   bit               rsp_calm    = 1'b0;
   int               rsp_stall_left = 0;
   int               rsp_calm_timer = 0;
   logic [KEY_W-1:0] inserted_keys [$];

   open_addressing_hash_table #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_quadratic  (req_quadratic),
      .req_phone_key  (req_phone_key),
      .req_payload_in (req_payload_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_probe_count(rsp_probe_count),
      .rsp_slot_index (rsp_slot_index),
      .rsp_payload_out(rsp_payload_out)
   );

   hash_table_checker #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_quadratic  (req_quadratic),
      .req_phone_key  (req_phone_key),
      .req_payload_in (req_payload_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_probe_count(rsp_probe_count),
      .rsp_slot_index (rsp_slot_index),
      .rsp_payload_out(rsp_payload_out),
      .failures       (failures),
      .outstanding    (outstanding),
      .search_hits    (search_hits),
      .full_inserts   (full_inserts)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // response side back-pressure, with quiet windows
   always @(negedge clock) begin
      if (rsp_calm_timer == 0) begin
         rsp_calm       = ($urandom_range(0, 3) == 0);
         rsp_calm_timer = $urandom_range(100, 300);
      end else begin
         rsp_calm_timer--;
      end
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_stall_left = pick_gap();
      end
   end

   // offer one request; entered and left at a falling edge
   task automatic send_request(logic kind, logic quad, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] pay);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_quadratic  <= quad;
      req_phone_key  <= key;
      req_payload_in <= pay;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      requests_sent++;
      if (kind == KIND_INSERT) inserted_keys.push_back(key);
   endtask

   // hold off new requests until every response is back
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic [KEY_W-1:0] random_key();
      return KEY_W'($urandom());
   endfunction

   // stimulus
   initial begin
      logic             kind;
      logic [KEY_W-1:0] key;
      int               insert_pct;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, collisions, duplicates, extremes, quadratic cycle
      send_request(KIND_SEARCH, 1'b1, 31'd0,          32'hFFFF_FFFF);
      send_request(KIND_INSERT, 1'b0, 31'd0,          32'h0000_0000);
      send_request(KIND_INSERT, 1'b0, 31'd16,         32'h0000_1234);
      send_request(KIND_INSERT, 1'b0, 31'd0,          32'hA5A5_A5A5);
      send_request(KIND_SEARCH, 1'b0, 31'd0,          32'h0000_0000);
      send_request(KIND_SEARCH, 1'b1, 31'd16,         32'h8000_0001);
      send_request(KIND_SEARCH, 1'b0, 31'd32,         32'h0000_0000);
      send_request(KIND_INSERT, 1'b1, 31'h7FFF_FFFF,  32'hFFFF_FFFF);
      send_request(KIND_INSERT, 1'b1, 31'd15,         32'h5555_5555);
      send_request(KIND_SEARCH, 1'b0, 31'h7FFF_FFFF,  32'h0000_0000);
      send_request(KIND_SEARCH, 1'b0, 31'd31,         32'hFFFF_FFFF);
      send_request(KIND_INSERT, 1'b0, 31'd4,          32'hAAAA_AAAA);
      send_request(KIND_INSERT, 1'b0, 31'd9,          32'h0F0F_0F0F);
      send_request(KIND_INSERT, 1'b1, 31'd48,         32'hDEAD_BEEF);
      send_request(KIND_SEARCH, 1'b0, 31'd15,         32'h0000_0000);
      send_request(KIND_SEARCH, 1'b0, 31'h7FFF_FFF0,  32'h0000_0000);
      wait_for_quiet();

      // random: inserts are rationed so the table fills slowly, then saturates
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) wait_for_quiet();
         insert_pct = (n < 450) ? 3 : 25;
         if ($urandom_range(0, 99) < insert_pct) begin
            kind = KIND_INSERT;
            if (inserted_keys.size() > 0 && $urandom_range(0, 4) == 0)
               key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            else
               key = random_key();
         end else begin
            kind = KIND_SEARCH;
            if (inserted_keys.size() > 0 && $urandom_range(0, 1) == 0)
               key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            else
               key = random_key();
         end
         send_request(kind, 1'($urandom_range(0, 1)), key, $urandom());
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("testbench: %0d requests sent, %0d search hits, %0d inserts refused",
               requests_sent, search_hits, full_inserts);
      if (failures == 0 && outstanding == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #12_000_000;
      $display("testbench: timed out with %0d responses outstanding", outstanding);
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== open_addressing_hash_table.f =====
+incdir+rtl
rtl/oaht_pkg.sv
rtl/oaht_home_mod.sv
rtl/oaht_slot_ram.sv
rtl/open_addressing_hash_table.sv
verif/hash_table_checker.sv
verif/testbench.sv
